### rtl/core/uuidgen_pkg.sv
// Shared types, constants and the xoshiro256++ step function for the UUIDv7 generator.
package uuidgen_pkg;

   localparam int unsigned WordWidth    = 64;
   localparam int unsigned TsWidth      = 48;
   localparam int unsigned SeqWidth     = 12;
   localparam int unsigned GenWords     = 4;
   localparam int unsigned RegIdxWidth  = 2;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned RandBits     = 62;

   localparam int unsigned RotSum   = 23;
   localparam int unsigned ShiftMix = 17;
   localparam int unsigned RotTail  = 45;

   localparam logic [3:0] UuidVersion = 4'h7;
   localparam logic [1:0] UuidVariant = 2'b10;

   // register indexes of the seed words
   localparam logic [RegIdxWidth-1:0] RegSeedA = 2'd0;
   localparam logic [RegIdxWidth-1:0] RegSeedB = 2'd1;
   localparam logic [RegIdxWidth-1:0] RegSeedC = 2'd2;
   localparam logic [RegIdxWidth-1:0] RegSeedD = 2'd3;

   localparam logic [WordWidth-1:0] SeedResetA = 64'd1;
   localparam logic [WordWidth-1:0] SeedResetB = 64'd0;
   localparam logic [WordWidth-1:0] SeedResetC = 64'd0;
   localparam logic [WordWidth-1:0] SeedResetD = 64'd0;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [GenWords-1:0] gen_state_type;

   typedef struct packed {
      gen_state_type state;
      word_type      value;
   } gen_step_type;

   // One xoshiro256++ advance: output value and next state.
   function automatic gen_step_type gen_advance(input gen_state_type s);
      gen_step_type r;
      word_type     sum;
      word_type     shifted;
      word_type     w0;
      word_type     w1;
      word_type     w2;
      word_type     w3;
      sum     = s[0] + s[3];
      r.value = {sum[WordWidth-1-RotSum:0], sum[WordWidth-1:WordWidth-RotSum]} + s[0];
      shifted = {s[1][WordWidth-1-ShiftMix:0], {ShiftMix{1'b0}}};
      w2 = s[2] ^ s[0];
      w3 = s[3] ^ s[1];
      w1 = s[1] ^ w2;
      w0 = s[0] ^ w3;
      w2 = w2 ^ shifted;
      w3 = {w3[WordWidth-1-RotTail:0], w3[WordWidth-1:WordWidth-RotTail]};
      r.state[0] = w0;
      r.state[1] = w1;
      r.state[2] = w2;
      r.state[3] = w3;
      return r;
   endfunction

endpackage

### rtl/core/uuidv7_generator_unit.sv
// Top level of the UUIDv7 generator: request/result pipeline, generator state and seed registers.
//   Request channel (req_valid / req_stall / req_timestamp_ms) brings a 48-bit
//   millisecond timestamp; the result channel (rsp_valid / rsp_stall /
//   rsp_uuid_upper / rsp_uuid_lower) returns one 128-bit UUIDv7 per request,
//   in request order. A transfer happens at a rising edge with valid high and
//   stall low.
//   Path: a request taken is latched in the input register; its UUID is
//   formed from there and loaded into the result register, which drives
//   rsp_valid, as soon as the result register is free.
//   Throughput: one request per cycle while the receiver does not stall. Both
//   generator advances (sequence reload and random field) are chained in the
//   single stage between the two registers, so the generator state never waits on itself.
//   Stall: when the receiver stalls, the result register holds; an empty
//   input register still takes one more request, and req_stall is high
//   while the input register holds a request, until the result is taken.
//   Reset (synchronous, active high) empties both registers, loads the seed
//   registers with 1,0,0,0, copies them to the generator and clears the last
//   timestamp and the sequence count.
//   CSR port: four 64-bit seed words at byte addresses 0, 8, 16, 24; a write
//   also loads that generator word. Write only while the block is idle.
module uuidv7_generator_unit
   import uuidgen_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [TsWidth-1:0]      req_timestamp_ms,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [WordWidth-1:0]    rsp_uuid_upper,
   output logic [WordWidth-1:0]    rsp_uuid_lower,
   // CSR port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [WordWidth-1:0]    csr_pwdata,
   output logic [WordWidth-1:0]    csr_prdata,
   output logic                    csr_pready
);

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [TsWidth-1:0] in_ts_ff, in_ts_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WordWidth-1:0] rsp_upper_ff, rsp_upper_in;
   logic [WordWidth-1:0] rsp_lower_ff, rsp_lower_in;

   // generator and sequence state
   gen_state_type        gen_ff, gen_in;
   logic [TsWidth-1:0]   prev_ts_ff, prev_ts_in;
   logic [SeqWidth-1:0]  seq_ff, seq_in;
   gen_state_type        seed_ff, seed_in;

   logic                   rsp_ready;
   logic                   advance;
   logic                   csr_write;
   logic [RegIdxWidth-1:0] csr_idx;
   logic                   ts_repeat;
   gen_step_type           step_seq;
   gen_step_type           step_rnd;
   gen_state_type          gen_mid;
   logic [SeqWidth-1:0]    seq_next;

   // Result register frees up when empty or being taken this cycle.
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && rsp_ready;
   assign req_stall = in_valid_ff && !rsp_ready;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CsrAddrWidth-1:CsrAddrWidth-RegIdxWidth];
   assign csr_pready = 1'b1;
   assign csr_prdata = seed_ff[csr_idx];

   // UUID formation: a new timestamp reloads the sequence from one advance,
   // a repeated one bumps it; a further advance always feeds the random bits.
   assign ts_repeat = (in_ts_ff == prev_ts_ff);
   assign step_seq  = gen_advance(gen_ff);
   assign gen_mid   = ts_repeat ? gen_ff : step_seq.state;
   assign seq_next  = ts_repeat ? seq_ff + SeqWidth'(1) : step_seq.value[SeqWidth-1:0];
   assign step_rnd  = gen_advance(gen_mid);

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_ts_in     = in_ts_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_upper_in = rsp_upper_ff;
      rsp_lower_in = rsp_lower_ff;
      gen_in       = gen_ff;
      prev_ts_in   = prev_ts_ff;
      seq_in       = seq_ff;
      seed_in      = seed_ff;

      // take a request whenever the input register is empty or moving on
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_ts_in    = req_timestamp_ms;
      end

      if (rsp_ready) begin
         rsp_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_upper_in = {in_ts_ff, UuidVersion, seq_next};
         rsp_lower_in = {UuidVariant, step_rnd.value[WordWidth-1:WordWidth-RandBits]};
         gen_in       = step_rnd.state;
         prev_ts_in   = in_ts_ff;
         seq_in       = seq_next;
      end

      // seeds must be written only while idle, not enforced; load both the register and the word
      if (csr_write) begin
         unique case (csr_idx)
            RegSeedA: begin
               seed_in[RegSeedA] = csr_pwdata;
               gen_in[RegSeedA]  = csr_pwdata;
            end
            RegSeedB: begin
               seed_in[RegSeedB] = csr_pwdata;
               gen_in[RegSeedB]  = csr_pwdata;
            end
            RegSeedC: begin
               seed_in[RegSeedC] = csr_pwdata;
               gen_in[RegSeedC]  = csr_pwdata;
            end
            RegSeedD: begin
               seed_in[RegSeedD] = csr_pwdata;
               gen_in[RegSeedD]  = csr_pwdata;
            end
            default: begin
               seed_in = seed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         prev_ts_ff        <= '0;
         seq_ff            <= '0;
         seed_ff[RegSeedA] <= SeedResetA;
         seed_ff[RegSeedB] <= SeedResetB;
         seed_ff[RegSeedC] <= SeedResetC;
         seed_ff[RegSeedD] <= SeedResetD;
         gen_ff[RegSeedA]  <= SeedResetA;
         gen_ff[RegSeedB]  <= SeedResetB;
         gen_ff[RegSeedC]  <= SeedResetC;
         gen_ff[RegSeedD]  <= SeedResetD;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ts_ff   <= prev_ts_in;
         seq_ff       <= seq_in;
         seed_ff      <= seed_in;
         gen_ff       <= gen_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_ts_ff     <= in_ts_in;
      rsp_upper_ff <= rsp_upper_in;
      rsp_lower_ff <= rsp_lower_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_uuid_upper = rsp_upper_ff;
   assign rsp_uuid_lower = rsp_lower_ff;

endmodule

### rtl/core/uuidgen_checker.sv
// Port-level checker for the UUIDv7 generator and its bind to the top level.
module uuidgen_checker
   import uuidgen_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [WordWidth-1:0]    rsp_uuid_upper,
   input logic [WordWidth-1:0]    rsp_uuid_lower
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_uuid_upper)
         && $stable(rsp_uuid_lower))
      else $error("stalled result changed");

   // version and variant fields are fixed on every result
   a_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_uuid_upper[15:12] == UuidVersion
         && rsp_uuid_lower[WordWidth-1:WordWidth-2] == UuidVariant)
      else $error("bad version or variant");

   // back-to-back results with the same timestamp count the sequence up by one
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1
         (rsp_valid && rsp_uuid_upper[WordWidth-1:16] == $past(rsp_uuid_upper[WordWidth-1:16]))
      |-> rsp_uuid_upper[SeqWidth-1:0] == $past(rsp_uuid_upper[SeqWidth-1:0]) + SeqWidth'(1))
      else $error("sequence did not increment");

   // nothing comes out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind uuidv7_generator_unit uuidgen_checker u_uuidgen_checker (.*);

### tb/sv/uuidv7_generator_unit_test.sv
// Self-checking testbench of the UUIDv7 generator: directed table, random phases, seed changes.
module uuidv7_generator_unit_test;
   import uuidgen_pkg::*;

   localparam int unsigned ResetCycles   = 7;
   localparam int unsigned HoldCycles    = 60;   // long receiver hold-off
   localparam int unsigned PhaseItems    = 100;
   localparam int unsigned Phases        = 8;
   localparam int unsigned QuietPhase    = 1;    // no gaps on either side
   localparam int unsigned PressurePhase = 3;    // receiver holds off once
   localparam int unsigned KeepSeedPhase = 5;    // generator keeps running, no reseed
   localparam int unsigned SettleCycles  = 2;    // allow margin after the last result
   localparam int unsigned DrainCycles   = 4;
   localparam int unsigned WatchdogLimit = 2000; // cycles without any transfer
   localparam int unsigned PrintLimit    = 100;
   localparam int unsigned RowCount      = 27;

   typedef logic [TsWidth-1:0]  stamp_type;
   typedef logic [SeqWidth-1:0] seq_type;

   typedef struct packed {
      word_type upper;
      word_type lower;
   } uuid_type;

   // per-request note: use the typed-in UUID instead of the predicted one
   typedef struct packed {
      logic     typed;
      uuid_type want;
   } note_type;

   typedef enum logic [0:0] {ROW_REQUEST, ROW_SEED} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [RegIdxWidth-1:0] index;   // seed register, for ROW_SEED
      word_type               value;   // timestamp or seed word
      logic                   typed;
      uuid_type               want;
   } row_type;

   // ------------------------------------------------------------------
   // Clock and DUT signals
   // ------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [TsWidth-1:0]      req_timestamp_ms;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [WordWidth-1:0]    rsp_uuid_upper;
   logic [WordWidth-1:0]    rsp_uuid_lower;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [WordWidth-1:0]    csr_pwdata;
   logic [WordWidth-1:0]    csr_prdata;
   logic                    csr_pready;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   uuidv7_generator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_timestamp_ms (req_timestamp_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_uuid_upper   (rsp_uuid_upper),
      .rsp_uuid_lower   (rsp_uuid_lower),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // ------------------------------------------------------------------
   // UUID predictor: own copy of seeds, xoshiro256++ words, last stamp
   // and sequence count
   // ------------------------------------------------------------------
   word_type  seed_words [GenWords];
   word_type  gen_words  [GenWords];
   stamp_type last_stamp;
   seq_type   seq_count;

   uuid_type  pending_uuids [$];  // expected UUIDs, oldest first
   note_type  typed_uuids   [$];  // one note per offered request
   int        mismatch_count = 0;
   int        stuck_cycles   = 0;
   bit        quiet          = 1'b0;
   bit        hold_pending   = 1'b0;

   function automatic word_type rotl(input word_type v, input int unsigned n);
      return (v << n) | (v >> (WordWidth - n));
   endfunction

   // advance the generator by one step and return its output
   function automatic word_type draw_xoshiro();
      word_type result_word;
      word_type spread;
      result_word  = rotl(gen_words[0] + gen_words[3], RotSum) + gen_words[0];
      spread       = gen_words[1] << ShiftMix;
      gen_words[2] = gen_words[2] ^ gen_words[0];
      gen_words[3] = gen_words[3] ^ gen_words[1];
      gen_words[1] = gen_words[1] ^ gen_words[2];
      gen_words[0] = gen_words[0] ^ gen_words[3];
      gen_words[2] = gen_words[2] ^ spread;
      gen_words[3] = rotl(gen_words[3], RotTail);
      return result_word;
   endfunction

   // UUID for one accepted timestamp; a repeat bumps the sequence (wraps at
   // 12 bits), a new stamp reloads it from one generator draw
   function automatic uuid_type next_uuid(input stamp_type ts);
      uuid_type u;
      word_type draw;
      if (ts == last_stamp) begin
         seq_count = seq_count + 1'b1;
      end else begin
         last_stamp = ts;
         draw       = draw_xoshiro();
         seq_count  = draw[SeqWidth-1:0];
      end
      draw    = draw_xoshiro();
      u.upper = {ts, UuidVersion, seq_count};
      u.lower = {UuidVariant, draw[WordWidth-1:2]};
      return u;
   endfunction

   task automatic report_mismatch(input string what, input word_type got,
                                  input word_type want);
      if (mismatch_count < PrintLimit)
         $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Transfer monitor: predict on each request transfer, check each
   // result transfer, and watch for a hung run. Sampled at the rising
   // edge, before any nonblocking update of that edge lands.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : transfer_monitor
      uuid_type got;
      uuid_type want;
      note_type note;
      if (!reset) begin
         stuck_cycles++;
         if (req_valid && !req_stall) begin
            stuck_cycles = 0;
            want = next_uuid(req_timestamp_ms);
            if (typed_uuids.size() != 0) begin
               note = typed_uuids.pop_front();
               if (note.typed)
                  want = note.want;
            end
            pending_uuids.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            stuck_cycles = 0;
            got = {rsp_uuid_upper, rsp_uuid_lower};
            if (pending_uuids.size() == 0) begin
               report_mismatch("result with no request, upper", got.upper, '0);
            end else begin
               want = pending_uuids.pop_front();
               if (got.upper !== want.upper)
                  report_mismatch("uuid_upper", got.upper, want.upper);
               if (got.lower !== want.lower)
                  report_mismatch("uuid_lower", got.lower, want.lower);
            end
         end
         if (csr_psel && csr_penable && csr_pready)
            stuck_cycles = 0;
         if (stuck_cycles >= WatchdogLimit) begin
            $display("uuidv7_generator_unit_test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, mostly short, a few long; none in the quiet
   // phase; one long hold-off on request so the block backs up.
   // ------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) != 0)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin : result_pacing
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pick_gap()) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender and CSR tasks; each is entered just after a rising edge and
   // returns just after one.
   // ------------------------------------------------------------------

   // offer one timestamp, optionally after a gap, and hold it until transfer
   task automatic send_stamp(input stamp_type ts, input logic typed, input uuid_type want);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      typed_uuids.push_back('{typed, want});
      req_valid        <= 1'b1;
      req_timestamp_ms <= ts;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait until every expected UUID has arrived
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_uuids.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // APB write: setup, access, then idle; load the shadow words
   task automatic csr_write(input logic [RegIdxWidth-1:0] index, input word_type value);
      csr_paddr   <= CsrAddrWidth'({index, 3'b000});
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      seed_words[index] = value;
      gen_words[index]  = value;
      @(posedge clock);
   endtask

   // APB read of one seed register, compared with the shadow seed
   task automatic csr_check(input logic [RegIdxWidth-1:0] index);
      word_type got;
      csr_paddr  <= CsrAddrWidth'({index, 3'b000});
      csr_pwrite <= 1'b0;
      csr_psel   <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== seed_words[index])
         report_mismatch("seed register read", got, seed_words[index]);
      @(posedge clock);
   endtask

   function automatic word_type pick_seed();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         2:       return word_type'(1) << $urandom_range(0, WordWidth - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly realistic clock behavior: repeats and small steps forward,
   // with some jumps, extremes and steps back mixed in
   function automatic stamp_type next_stamp(input stamp_type ts);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return ts;
      if (roll < 85)
         return ts + stamp_type'($urandom_range(1, 3));
      if (roll < 93)
         return stamp_type'({$urandom, $urandom});
      if (roll < 96)
         return ($urandom_range(0, 1) != 0) ? '1 : '0;
      return ts - 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Directed table. Typed-in UUIDs only where they are plain to see:
   // the first request after reset, and the all-zero generator.
   // ------------------------------------------------------------------
   row_type directed_rows [RowCount] = '{
      // first request at time zero counts as a repeat: sequence 1, one draw
      '{ROW_REQUEST, RegSeedA, 64'h0, 1'b1,
        '{64'h0000_0000_0000_7001, 64'h8000_0000_0020_0000}},
      '{ROW_REQUEST, RegSeedA, 64'h0, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'h1, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'hFFFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'hFFFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'h5555_5555_5555, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'hAAAA_AAAA_AAAA, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'h8000_0000_0000, 1'b0, '0},
      // this seed makes the next sequence reload 0xfff, so a repeat wraps to 0
      '{ROW_SEED, RegSeedA, 64'h0FFF, 1'b0, '0},
      '{ROW_SEED, RegSeedB, 64'h0, 1'b0, '0},
      '{ROW_SEED, RegSeedC, 64'h0, 1'b0, '0},
      '{ROW_SEED, RegSeedD, 64'h0, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'h123, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'h123, 1'b0, '0},
      // all-zero generator: random parts stay zero
      '{ROW_SEED, RegSeedA, 64'h0, 1'b0, '0},
      '{ROW_SEED, RegSeedB, 64'h0, 1'b0, '0},
      '{ROW_SEED, RegSeedC, 64'h0, 1'b0, '0},
      '{ROW_SEED, RegSeedD, 64'h0, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'h123, 1'b1,
        '{64'h0000_0000_0123_7001, 64'h8000_0000_0000_0000}},
      '{ROW_REQUEST, RegSeedA, 64'h456, 1'b1,
        '{64'h0000_0000_0456_7000, 64'h8000_0000_0000_0000}},
      // all-ones seeds
      '{ROW_SEED, RegSeedA, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_SEED, RegSeedB, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_SEED, RegSeedC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_SEED, RegSeedD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'h456, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'h0, 1'b0, '0},
      '{ROW_REQUEST, RegSeedA, 64'hFFFF_FFFF_FFFF, 1'b0, '0}
   };

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      stamp_type ts;
      row_type   row;
      int unsigned p;
      int unsigned k;
      int unsigned i;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_timestamp_ms <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;

      // mirror the reset state in the predictor
      seed_words = '{SeedResetA, SeedResetB, SeedResetC, SeedResetD};
      gen_words  = seed_words;
      last_stamp = '0;
      seq_count  = '0;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // seed registers come out of reset as 1, 0, 0, 0
      for (i = 0; i < GenWords; i++)
         csr_check(RegIdxWidth'(i));

      // walk the directed table; seed writes only once the block is drained
      for (i = 0; i < RowCount; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_SEED) begin
            wait_idle();
            csr_write(row.index, row.value);
            csr_check(row.index);
         end else begin
            send_stamp(TsWidth'(row.value), row.typed, row.want);
         end
      end

      // random phases, each starting idle with fresh seeds (except one)
      ts = '0;
      for (p = 0; p < Phases; p++) begin
         wait_idle();
         if (p != KeepSeedPhase) begin
            for (i = 0; i < GenWords; i++) begin
               csr_write(RegIdxWidth'(i), pick_seed());
               csr_check(RegIdxWidth'(i));
            end
         end
         quiet = (p == QuietPhase);
         if (p == PressurePhase)
            hold_pending = 1'b1;
         for (k = 0; k < PhaseItems; k++) begin
            ts = next_stamp(ts);
            send_stamp(ts, 1'b0, '0);
         end
      end

      // drain, then leave room for any stray result to show up
      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("uuidv7_generator_unit_test passed");
      else
         $display("uuidv7_generator_unit_test failed");
      $finish;
   end

endmodule
